### rtl/nts_pkg.sv
// Shared types and constants for the nested type syntax checker.
// No dependencies; used by every module in rtl/.
package nts_pkg;

   localparam int MAX_DEPTH_DEFAULT  = 16;
   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] CH_LSQUARE    = 8'h5b;
   localparam logic [7:0] CH_RSQUARE    = 8'h5d;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_LANGLE     = 8'h3c;
   localparam logic [7:0] CH_RANGLE     = 8'h3e;
   localparam logic [7:0] CH_STAR       = 8'h2a;
   localparam logic [7:0] CH_COMMA      = 8'h2c;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SQUARE,
      KIND_PAREN,
      KIND_ANGLE
   } kind_type;

   typedef enum logic [1:0] {
      PH_ID_START,
      PH_ID_REST,
      PH_STARS,
      PH_LIST_FIRST
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_EMPTY_ID,
      ST_BAD_ID_START,
      ST_NOTHING_AFTER,
      ST_COMMA_EXPECTED,
      ST_UNTERMINATED,
      ST_TOO_DEEP
   } status_type;

   typedef struct packed {
      logic     has_char;
      logic     last;
      logic     alpha;
      logic     digit;
      logic     star;
      logic     comma;
      kind_type opener;
      kind_type closer;
   } token_type;

endpackage

### rtl/nested_type_syntax_checker.sv
// Nested type syntax checker, top level: front end, queue, back end.
// Throughput: one character per cycle while req_stall is low.
// After the last item is accepted, it passes through the queue and then the
// result register before the result appears.
// Reset: synchronous, active high; clears parse state, index counter,
// base_index and queue; the closer stack memory is not cleared.
module nested_type_syntax_checker #(
   parameter int MAX_DEPTH  = nts_pkg::MAX_DEPTH_DEFAULT,
   parameter int INDEX_BITS = nts_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_ch,
   input  logic                  req_has_char,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [INDEX_BITS-1:0] rsp_position,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_base_index
);

   localparam int QW = $bits(nts_pkg::token_type) + 2 * INDEX_BITS;

   logic                  push, pop, full, head_valid;
   nts_pkg::token_type    f_token, b_token;
   logic [INDEX_BITS-1:0] f_char_pos, f_end_pos, b_char_pos, b_end_pos;
   logic [QW-1:0]         push_data, head_data;

   assign req_stall = full;
   assign csr_ready = 1'b1;
   assign push_data = {f_token, f_char_pos, f_end_pos};
   assign {b_token, b_char_pos, b_end_pos} = head_data;

   nts_front #(
      .INDEX_BITS(INDEX_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ch         (req_ch),
      .req_has_char   (req_has_char),
      .req_last       (req_last),
      .queue_full     (full),
      .csr_valid      (csr_valid),
      .csr_base_index (csr_base_index),
      .push           (push),
      .token          (f_token),
      .char_pos       (f_char_pos),
      .end_pos        (f_end_pos)
   );

   nts_queue #(
      .DEPTH(nts_pkg::QUEUE_DEPTH),
      .WIDTH(QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   nts_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .INDEX_BITS(INDEX_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .token        (b_token),
      .char_pos     (b_char_pos),
      .end_pos      (b_end_pos),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position)
   );

endmodule

### rtl/nts_front.sv
// Front end: accepts characters, classifies them and tracks the index.
// Holds the base_index register. Depends on nts_pkg.
module nts_front #(
   parameter int INDEX_BITS = nts_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_ch,
   input  logic                  req_has_char,
   input  logic                  req_last,
   input  logic                  queue_full,
   input  logic                  csr_valid,
   input  logic [15:0]           csr_base_index,
   output logic                  push,
   output nts_pkg::token_type    token,
   output logic [INDEX_BITS-1:0] char_pos,
   output logic [INDEX_BITS-1:0] end_pos
);

   logic [INDEX_BITS-1:0] base_ff, base_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;

   assign push = req_valid && !queue_full;

   always_comb begin
      token.has_char = req_has_char;
      token.last     = req_last;
      token.alpha    = (req_ch inside {[8'h41:8'h5a], [8'h61:8'h7a]})
                       || req_ch == nts_pkg::CH_UNDERSCORE;
      token.digit    = req_ch inside {[8'h30:8'h39]};
      token.star     = req_ch == nts_pkg::CH_STAR;
      token.comma    = req_ch == nts_pkg::CH_COMMA;
      case (req_ch)
         nts_pkg::CH_LSQUARE: token.opener = nts_pkg::KIND_SQUARE;
         nts_pkg::CH_LPAREN:  token.opener = nts_pkg::KIND_PAREN;
         nts_pkg::CH_LANGLE:  token.opener = nts_pkg::KIND_ANGLE;
         default:             token.opener = nts_pkg::KIND_NONE;
      endcase
      case (req_ch)
         nts_pkg::CH_RSQUARE: token.closer = nts_pkg::KIND_SQUARE;
         nts_pkg::CH_RPAREN:  token.closer = nts_pkg::KIND_PAREN;
         nts_pkg::CH_RANGLE:  token.closer = nts_pkg::KIND_ANGLE;
         default:             token.closer = nts_pkg::KIND_NONE;
      endcase
   end

   assign char_pos = base_ff + count_ff;
   assign end_pos  = char_pos + INDEX_BITS'(req_has_char);

   always_comb begin
      base_in  = csr_valid ? INDEX_BITS'(csr_base_index) : base_ff;
      count_in = count_ff;
      if (push) begin
         count_in = req_last ? '0 : count_ff + INDEX_BITS'(req_has_char);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/nts_queue.sv
// Small FIFO between the front and back ends.
// Generic storage, no package dependencies beyond nts_pkg defaults.
module nts_queue #(
   parameter int DEPTH = nts_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = store_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/nts_back.sv
// Back end: parse state machine, closer stack and result register.
// Depends on nts_pkg.
module nts_back #(
   parameter int MAX_DEPTH  = nts_pkg::MAX_DEPTH_DEFAULT,
   parameter int INDEX_BITS = nts_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  nts_pkg::token_type    token,
   input  logic [INDEX_BITS-1:0] char_pos,
   input  logic [INDEX_BITS-1:0] end_pos,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [INDEX_BITS-1:0] rsp_position
);

   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DW = $clog2(MAX_DEPTH + 1);

   nts_pkg::phase_type    phase_ff, phase_in, ph_n;
   logic                  fin_ff, fin_in, fin_n;
   nts_pkg::status_type   status_ff, status_in, st_n;
   logic [INDEX_BITS-1:0] hpos_ff, hpos_in, hp_n;
   logic [DW-1:0]         depth_ff, depth_in, depth_n;
   nts_pkg::kind_type     top_ff, top_in;
   nts_pkg::kind_type     below_ff;
   nts_pkg::kind_type     stack_mem [MAX_DEPTH];
   logic                  push_k, pop_k, ended, closer_hit, out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   nts_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign pop          = head_valid && (!token.last || out_free);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;

   always_comb begin
      ph_n       = phase_ff;
      fin_n      = fin_ff;
      st_n       = status_ff;
      hp_n       = hpos_ff;
      push_k     = 1'b0;
      pop_k      = 1'b0;
      ended      = 1'b0;
      closer_hit = depth_ff != '0 && token.closer != nts_pkg::KIND_NONE
                   && token.closer == top_ff;

      if (token.has_char && !fin_ff) begin
         case (phase_ff)
            nts_pkg::PH_ID_START: begin
               if (token.alpha) begin
                  ph_n = nts_pkg::PH_ID_REST;
               end else begin
                  fin_n = 1'b1;
                  st_n  = nts_pkg::ST_BAD_ID_START;
                  hp_n  = char_pos;
               end
            end
            nts_pkg::PH_ID_REST: begin
               if (token.alpha || token.digit) begin
                  ph_n = nts_pkg::PH_ID_REST;
               end else if (token.opener != nts_pkg::KIND_NONE) begin
                  if (depth_ff == DW'(MAX_DEPTH)) begin
                     fin_n = 1'b1;
                     st_n  = nts_pkg::ST_TOO_DEEP;
                     hp_n  = char_pos;
                  end else begin
                     push_k = 1'b1;
                     ph_n   = nts_pkg::PH_LIST_FIRST;
                  end
               end else if (token.star) begin
                  ph_n = nts_pkg::PH_STARS;
               end else begin
                  ended = 1'b1;
               end
            end
            nts_pkg::PH_STARS: begin
               ended = !token.star;
            end
            default: begin
               if (closer_hit) begin
                  pop_k = 1'b1;
                  ph_n  = nts_pkg::PH_STARS;
               end else if (token.alpha) begin
                  ph_n = nts_pkg::PH_ID_REST;
               end else begin
                  fin_n = 1'b1;
                  st_n  = nts_pkg::ST_BAD_ID_START;
                  hp_n  = char_pos;
               end
            end
         endcase
      end

      if (ended) begin
         if (depth_ff == '0) begin
            fin_n = 1'b1;
            st_n  = nts_pkg::ST_OK;
            hp_n  = char_pos;
         end else if (closer_hit) begin
            pop_k = 1'b1;
            ph_n  = nts_pkg::PH_STARS;
         end else if (token.comma) begin
            ph_n = nts_pkg::PH_ID_START;
         end else begin
            fin_n = 1'b1;
            st_n  = nts_pkg::ST_COMMA_EXPECTED;
            hp_n  = char_pos;
         end
      end

      depth_n = depth_ff;
      if (push_k) begin
         depth_n = depth_ff + 1'b1;
      end else if (pop_k) begin
         depth_n = depth_ff - 1'b1;
      end

      if (token.last && !fin_n) begin
         hp_n = end_pos;
         case (ph_n)
            nts_pkg::PH_ID_START: st_n = nts_pkg::ST_EMPTY_ID;
            nts_pkg::PH_ID_REST,
            nts_pkg::PH_STARS:
               st_n = (depth_n == '0) ? nts_pkg::ST_OK : nts_pkg::ST_UNTERMINATED;
            default: st_n = nts_pkg::ST_NOTHING_AFTER;
         endcase
      end

      phase_in      = phase_ff;
      fin_in        = fin_ff;
      status_in     = status_ff;
      hpos_in       = hpos_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (pop) begin
         if (push_k) begin
            top_in = token.opener;
         end else if (pop_k) begin
            top_in = below_ff;
         end
         if (token.last) begin
            phase_in      = nts_pkg::PH_ID_START;
            fin_in        = 1'b0;
            status_in     = nts_pkg::ST_OK;
            hpos_in       = '0;
            depth_in      = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = st_n;
            rsp_pos_in    = hp_n;
         end else begin
            phase_in  = ph_n;
            fin_in    = fin_n;
            status_in = st_n;
            hpos_in   = hp_n;
            depth_in  = depth_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= nts_pkg::PH_ID_START;
         fin_ff       <= 1'b0;
         status_ff    <= nts_pkg::ST_OK;
         hpos_ff      <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         status_ff    <= status_in;
         hpos_ff      <= hpos_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   // stack_mem holds every open entry; below_ff tracks the entry under the top
   always_ff @(posedge clock) begin
      if (pop && push_k) begin
         stack_mem[AW'(depth_ff)] <= token.opener;
      end
      if (depth_in >= DW'(2)) begin
         below_ff <= stack_mem[AW'(depth_in - DW'(2))];
      end
   end

endmodule
